### design/gmd_pkg.sv
// Shared constants and codes for the grid maze depth-first solver.
package gmd_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int CELLS      = MAX_ROWS * MAX_COLS;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int DEPTH_W    = ADDR_W + 1;
    localparam int DIR_W      = 3;
    localparam int STEPS_W    = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // Item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_SOLVE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_COL = 1'd1;

    // Search directions
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

    // Mark entry bits: visited during search, on final path
    localparam int MARK_W = 2;
    localparam logic [MARK_W-1:0] MARK_NONE  = 2'b00;
    localparam logic [MARK_W-1:0] MARK_VISIT = 2'b10;
    localparam logic [MARK_W-1:0] MARK_PATH  = 2'b11;

    localparam int STK_W = ROW_W + COL_W + DIR_W;

endpackage

### design/gmd_in_if.sv
// Input channel: command word with valid/ready handshake.
interface gmd_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [gmd_pkg::ROW_W-1:0] row;
    logic [gmd_pkg::COL_W-1:0] col;
    logic                     wall;

    modport source (output valid, kind, row, col, wall, input ready);
    modport sink   (input valid, kind, row, col, wall, output ready);
endinterface

### design/gmd_out_if.sv
// Output channel: result word with valid/ready handshake.
interface gmd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [gmd_pkg::ROW_W-1:0]   exit_row;
    logic [gmd_pkg::COL_W-1:0]   exit_col;
    logic [gmd_pkg::STEPS_W-1:0] path_steps;
    logic                        on_path;

    modport source (output valid, found, exit_row, exit_col, path_steps, on_path,
                    input ready);
    modport sink   (input valid, found, exit_row, exit_col, path_steps, on_path,
                    output ready);
endinterface

### design/grid_maze_dfs_solver.sv
// Write words: one per cycle while results are taken, result valid the cycle after acceptance.
// Read words: mark memory read at acceptance, result registered in S_READ; no word taken in S_READ.
// Solve word: mark clearing pass over all 4096 cells, then S_PROBE and S_CHECK per direction tried
// (wall/mark memory read), S_PROBE and S_POP per backtrack, S_MARK and S_MARKW per path cell.
// The next word is taken once the solve result is loaded into the output register.
// Reset (synchronous, active low) runs the clearing pass over all 4096 cells; no word is taken meanwhile.
module grid_maze_dfs_solver (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    gmd_in_if.sink                           i_req,
    gmd_out_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [gmd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gmd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gmd_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_START, S_PROBE, S_CHECK, S_POP,
        S_MARK, S_MARKW, S_MARKTOP, S_READ
    } t_state;

    t_state               r_state;
    logic                 r_solve;
    logic [ADDR_W-1:0]    r_idx;
    logic [ROW_W-1:0]     r_last_row;
    logic [COL_W-1:0]     r_last_col;
    logic [ROW_W-1:0]     r_start_row;
    logic [COL_W-1:0]     r_start_col;
    logic [ROW_W-1:0]     r_top_row;
    logic [COL_W-1:0]     r_top_col;
    logic [DIR_W-1:0]     r_dir;
    logic [DEPTH_W-1:0]   r_depth;
    logic [ROW_W-1:0]     r_nbr_row;
    logic [COL_W-1:0]     r_nbr_col;
    logic                 r_ov;
    logic                 r_found;
    logic [ROW_W-1:0]     r_exit_row;
    logic [COL_W-1:0]     r_exit_col;
    logic [STEPS_W-1:0]   r_steps;
    logic                 r_on_path;

    logic                 accept;
    logic [ROW_W-1:0]     nbr_row;
    logic [COL_W-1:0]     nbr_col;
    logic [DEPTH_W-1:0]   depth_m1;
    logic [DEPTH_W-1:0]   depth_m2;
    logic                 start_in;
    logic                 start_border;
    logic                 nbr_border;

    logic                 vis_we;
    logic [ADDR_W-1:0]    vis_waddr;
    logic [MARK_W-1:0]    vis_wdata;
    logic [ADDR_W-1:0]    vis_raddr;
    logic [MARK_W-1:0]    vis_rdata;
    logic                 wall_we;
    logic [0:0]           wall_rdata;
    logic                 stk_we;
    logic [ADDR_W-1:0]    stk_waddr;
    logic [ADDR_W-1:0]    stk_raddr;
    logic [STK_W-1:0]     stk_rdata;
    logic [ROW_W-1:0]     stk_row;
    logic [COL_W-1:0]     stk_col;
    logic [DIR_W-1:0]     stk_dir;

    function automatic logic is_border(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                       input logic [ROW_W-1:0] lr,
                                       input logic [COL_W-1:0] lc);
        is_border = (r == '0) || (c == '0) || (r == lr) || (c == lc);
    endfunction

    assign i_req.ready = (r_state == S_IDLE) && (!r_ov || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    assign o_rsp.valid      = r_ov;
    assign o_rsp.found      = r_found;
    assign o_rsp.exit_row   = r_exit_row;
    assign o_rsp.exit_col   = r_exit_col;
    assign o_rsp.path_steps = r_steps;
    assign o_rsp.on_path    = r_on_path;

    assign depth_m1 = r_depth - DEPTH_W'(1);
    assign depth_m2 = r_depth - DEPTH_W'(2);
    assign {stk_row, stk_col, stk_dir} = stk_rdata;

    // Neighbor of the top cell in the current direction
    always_comb begin
        nbr_row = r_top_row;
        nbr_col = r_top_col;
        case (r_dir)
            DIR_UP:    nbr_row = r_top_row - ROW_W'(1);
            DIR_RIGHT: nbr_col = r_top_col + COL_W'(1);
            DIR_DOWN:  nbr_row = r_top_row + ROW_W'(1);
            default:   nbr_col = r_top_col - COL_W'(1);
        endcase
    end

    assign start_in     = (r_start_row <= r_last_row) && (r_start_col <= r_last_col);
    assign start_border = is_border(r_start_row, r_start_col, r_last_row, r_last_col);
    assign nbr_border   = is_border(r_nbr_row, r_nbr_col, r_last_row, r_last_col);

    // Steer memory ports
    always_comb begin
        vis_we    = 1'b0;
        vis_waddr = r_idx;
        vis_wdata = MARK_NONE;
        vis_raddr = {nbr_row, nbr_col};
        wall_we   = 1'b0;
        stk_we    = 1'b0;
        stk_waddr = depth_m1[ADDR_W-1:0];
        stk_raddr = r_idx;
        unique case (r_state)
            S_CLEAR: begin
                vis_we = 1'b1;
            end
            S_IDLE: begin
                if (accept && i_req.kind == KIND_WRITE) begin
                    wall_we = 1'b1;
                end
                vis_raddr = {i_req.row, i_req.col};
            end
            S_START: begin
                if (start_in) begin
                    vis_we    = 1'b1;
                    vis_waddr = {r_start_row, r_start_col};
                    vis_wdata = start_border ? MARK_PATH : MARK_VISIT;
                end
            end
            S_PROBE: begin
                stk_raddr = depth_m2[ADDR_W-1:0];
            end
            S_CHECK: begin
                if (!wall_rdata[0] && !vis_rdata[1]) begin
                    vis_waddr = {r_nbr_row, r_nbr_col};
                    if (nbr_border) begin
                        vis_we    = 1'b1;
                        vis_wdata = MARK_PATH;
                    end else if (r_depth != DEPTH_W'(CELLS)) begin
                        vis_we    = 1'b1;
                        vis_wdata = MARK_VISIT;
                        stk_we    = 1'b1;
                    end
                end
            end
            S_MARKW: begin
                vis_we    = 1'b1;
                vis_waddr = {stk_row, stk_col};
                vis_wdata = MARK_PATH;
            end
            S_MARKTOP: begin
                vis_we    = 1'b1;
                vis_waddr = {r_top_row, r_top_col};
                vis_wdata = MARK_PATH;
            end
            default: begin
            end
        endcase
    end

    gmd_ram #(.WIDTH(MARK_W), .DEPTH(CELLS)) u_mark (
        .i_clk  (i_clk),
        .i_we   (vis_we),
        .i_waddr(vis_waddr),
        .i_wdata(vis_wdata),
        .i_raddr(vis_raddr),
        .o_rdata(vis_rdata)
    );

    gmd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
        .i_clk  (i_clk),
        .i_we   (wall_we),
        .i_waddr({i_req.row, i_req.col}),
        .i_wdata(i_req.wall),
        .i_raddr({nbr_row, nbr_col}),
        .o_rdata(wall_rdata)
    );

    gmd_ram #(.WIDTH(STK_W), .DEPTH(CELLS)) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata({r_top_row, r_top_col, r_dir}),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    // Hold state, search registers and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_solve    <= 1'b0;
            r_idx      <= '0;
            r_ov       <= 1'b0;
            r_last_row <= ROW_W'(63);
            r_last_col <= COL_W'(63);
            r_depth    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LAST_ROW) r_last_row <= i_cfg_data[ROW_W-1:0];
                if (i_cfg_idx == CFG_LAST_COL) r_last_col <= i_cfg_data[COL_W-1:0];
            end
            if (o_rsp.valid && o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + ADDR_W'(1);
                    if (r_idx == '1) begin
                        r_state <= r_solve ? S_START : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_found    <= 1'b0;
                        r_exit_row <= '0;
                        r_exit_col <= '0;
                        r_steps    <= '0;
                        r_on_path  <= 1'b0;
                        case (i_req.kind)
                            KIND_SOLVE: begin
                                r_solve     <= 1'b1;
                                r_idx       <= '0;
                                r_start_row <= i_req.row;
                                r_start_col <= i_req.col;
                                r_state     <= S_CLEAR;
                            end
                            KIND_READ: r_state <= S_READ;
                            default:   r_ov    <= 1'b1;
                        endcase
                    end
                end
                S_READ: begin
                    r_on_path <= vis_rdata[0];
                    r_ov      <= 1'b1;
                    r_state   <= S_IDLE;
                end
                S_START: begin
                    r_solve   <= 1'b0;
                    r_top_row <= r_start_row;
                    r_top_col <= r_start_col;
                    r_dir     <= DIR_UP;
                    r_depth   <= DEPTH_W'(1);
                    if (!start_in) begin
                        r_depth <= '0;
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (start_border) begin
                        r_depth    <= '0;
                        r_found    <= 1'b1;
                        r_exit_row <= r_start_row;
                        r_exit_col <= r_start_col;
                        r_ov       <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_dir == DIR_DONE) begin
                        r_depth <= depth_m1;
                        if (r_depth == DEPTH_W'(1)) begin
                            r_ov    <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_POP;
                        end
                    end else begin
                        r_nbr_row <= nbr_row;
                        r_nbr_col <= nbr_col;
                        r_dir     <= r_dir + DIR_W'(1);
                        r_state   <= S_CHECK;
                    end
                end
                S_POP: begin
                    r_top_row <= stk_row;
                    r_top_col <= stk_col;
                    r_dir     <= stk_dir;
                    r_state   <= S_PROBE;
                end
                S_CHECK: begin
                    r_state <= S_PROBE;
                    if (!wall_rdata[0] && !vis_rdata[1]) begin
                        if (nbr_border) begin
                            r_found    <= 1'b1;
                            r_exit_row <= r_nbr_row;
                            r_exit_col <= r_nbr_col;
                            r_steps    <= r_depth[STEPS_W-1:0];
                            r_idx      <= '0;
                            r_state    <= (r_depth == DEPTH_W'(1)) ? S_MARKTOP : S_MARK;
                        end else if (r_depth != DEPTH_W'(CELLS)) begin
                            r_top_row <= r_nbr_row;
                            r_top_col <= r_nbr_col;
                            r_dir     <= DIR_UP;
                            r_depth   <= r_depth + DEPTH_W'(1);
                        end
                    end
                end
                S_MARK: begin
                    r_state <= S_MARKW;
                end
                S_MARKW: begin
                    r_idx <= r_idx + ADDR_W'(1);
                    if (r_idx == depth_m2[ADDR_W-1:0]) begin
                        r_state <= S_MARKTOP;
                    end else begin
                        r_state <= S_MARK;
                    end
                end
                S_MARKTOP: begin
                    r_depth <= '0;
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Words are taken only while idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> r_state == S_IDLE)
        else $error("word taken outside idle");

    // A probe result is always checked right after the probe
    a_check_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> $past(r_state) == S_PROBE)
        else $error("check without probe");

    // The search never runs with an empty stack
    a_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_CHECK) |-> r_depth != '0)
        else $error("search with empty stack");

    // Path marking only follows a found exit
    a_mark_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MARKTOP |-> r_found)
        else $error("path marked without exit");
endmodule

### design/gmd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module gmd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then read registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### verif/tb_grid_maze_dfs_solver.sv
// Testbench for grid_maze_dfs_solver: directed table, then random maze phases checked by a predictor.
`timescale 1ns / 1ps

module tb_grid_maze_dfs_solver;
    import gmd_pkg::*;

    localparam int LIMIT_CYCLES = 40_000_000;
    localparam int IDLE_PCT     = 32;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic                found;
        logic [ROW_W-1:0]    exit_row;
        logic [COL_W-1:0]    exit_col;
        logic [STEPS_W-1:0]  path_steps;
        logic                on_path;
    } result_t;

    typedef struct {
        logic [1:0]       kind;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             wall;
        bit               typed;
        result_t          res;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gmd_in_if  req ();
    gmd_out_if rsp ();

    grid_maze_dfs_solver u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req.sink),
        .o_rsp      (rsp.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: wall map, path marks, search stack, border registers
    bit               maze_wall  [CELLS];
    bit               maze_known [CELLS];
    bit               path_mark  [CELLS];
    int               dfs_row    [CELLS];
    int               dfs_col    [CELLS];
    int               dfs_dir    [CELLS];
    int               border_row;
    int               border_col;

    result_t          pending_results[$];
    int               errors = 0;
    int               cycles = 0;
    int               results_seen = 0;
    int               solves_sent;
    int               exits_found;
    int               reads_sent;
    bit               quiet;

    dir_row_t         directed[$];

    always #5 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_grid_maze_dfs_solver failed");
            $finish;
        end
    end

    function automatic bit at_border(int r, int c);
        return r == 0 || c == 0 || r == border_row || c == border_col;
    endfunction

    // Depth-first search over the predictor's copy of the maze
    function automatic result_t solve_maze(int sr, int sc);
        result_t res;
        int depth;
        int r;
        int c;
        int d;
        int nr;
        int nc;
        res = '0;
        path_mark = '{default: 0};
        if (sr > border_row || sc > border_col) return res;
        if (at_border(sr, sc)) begin
            path_mark[sr * MAX_COLS + sc] = 1;
            res.found = 1;
            res.exit_row = ROW_W'(sr);
            res.exit_col = COL_W'(sc);
            return res;
        end
        path_mark[sr * MAX_COLS + sc] = 1;
        dfs_row[0] = sr;
        dfs_col[0] = sc;
        dfs_dir[0] = DIR_UP;
        depth = 1;
        while (depth > 0) begin
            r = dfs_row[depth-1];
            c = dfs_col[depth-1];
            d = dfs_dir[depth-1];
            if (d >= DIR_DONE) begin
                depth--;
                continue;
            end
            dfs_dir[depth-1] = d + 1;
            nr = r;
            nc = c;
            case (d)
                DIR_UP:    nr = r - 1;
                DIR_RIGHT: nc = c + 1;
                DIR_DOWN:  nr = r + 1;
                default:   nc = c - 1;
            endcase
            if (maze_wall[nr * MAX_COLS + nc] || path_mark[nr * MAX_COLS + nc]) continue;
            if (at_border(nr, nc)) begin
                res.found = 1;
                res.exit_row = ROW_W'(nr);
                res.exit_col = COL_W'(nc);
                res.path_steps = STEPS_W'(depth);
                // keep only the cells still on the stack, plus the exit
                path_mark = '{default: 0};
                for (int i = 0; i < depth; i++) path_mark[dfs_row[i] * MAX_COLS + dfs_col[i]] = 1;
                path_mark[nr * MAX_COLS + nc] = 1;
                return res;
            end
            if (depth >= CELLS) continue;
            path_mark[nr * MAX_COLS + nc] = 1;
            dfs_row[depth] = nr;
            dfs_col[depth] = nc;
            dfs_dir[depth] = DIR_UP;
            depth++;
        end
        path_mark = '{default: 0};
        return res;
    endfunction

    function automatic result_t predict_word(logic [1:0] kind, int r, int c, logic wall);
        result_t res;
        res = '0;
        case (kind)
            KIND_WRITE: maze_wall[r * MAX_COLS + c] = wall;
            KIND_SOLVE: res = solve_maze(r, c);
            KIND_READ:  res.on_path = path_mark[r * MAX_COLS + c];
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    // Compare each result word with the oldest expectation
    always @(negedge i_clk) begin
        result_t want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word, queue depth", 0, 1);
            end else begin
                want = pending_results.pop_front();
                if (rsp.found !== want.found) report_mismatch("found", rsp.found, want.found);
                if (rsp.exit_row !== want.exit_row)
                    report_mismatch("exit_row", rsp.exit_row, want.exit_row);
                if (rsp.exit_col !== want.exit_col)
                    report_mismatch("exit_col", rsp.exit_col, want.exit_col);
                if (rsp.path_steps !== want.path_steps)
                    report_mismatch("path_steps", rsp.path_steps, want.path_steps);
                if (rsp.on_path !== want.on_path)
                    report_mismatch("on_path", rsp.on_path, want.on_path);
            end
        end
    end

    // Result side: random stalls, one long hold-off after a few hundred words
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(posedge i_clk) begin
        if (!hold_done && results_seen >= 300) begin
            hold_done <= 1;
            hold_left <= 400;
            rsp.ready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp.ready <= 0;
        end else begin
            rsp.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one word with a random gap first; return at its accepting edge
    task automatic send_word(logic [1:0] kind, int r, int c, logic wall, bit typed,
                             result_t typed_res);
        bit taken;
        result_t want;
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            req.valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        req.valid <= 1;
        req.kind  <= kind;
        req.row   <= ROW_W'(r);
        req.col   <= COL_W'(c);
        req.wall  <= wall;
        do begin
            @(negedge i_clk);
            taken = req.ready;
            @(posedge i_clk);
        end while (!taken);
        want = predict_word(kind, r, c, wall);
        pending_results.push_back(typed ? typed_res : want);
        if (kind == KIND_WRITE) maze_known[r * MAX_COLS + c] = 1;
        if (kind == KIND_SOLVE) begin
            solves_sent++;
            exits_found += want.found;
        end
        if (kind == KIND_READ) reads_sent++;
    endtask

    // Open every never-written cell inside the borders, back to back
    task automatic fill_region();
        quiet = 1;
        for (int r = 0; r <= border_row; r++)
            for (int c = 0; c <= border_col; c++)
                if (!maze_known[r * MAX_COLS + c]) send_word(KIND_WRITE, r, c, 0, 1, '0);
        quiet = 0;
    endtask

    // Drain, let the block settle, write both border registers, open the new region
    task automatic set_borders(int lr, int lc);
        req.valid <= 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_idx  <= CFG_LAST_ROW;
        i_cfg_data <= CFG_DATA_W'(lr);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LAST_COL;
        i_cfg_data <= CFG_DATA_W'(lc);
        @(posedge i_clk);
        i_cfg_we   <= 0;
        border_row = lr;
        border_col = lc;
        @(posedge i_clk);
        fill_region();
    endtask

    function automatic result_t mk_res(bit f, int er, int ec, int st, bit p);
        result_t res;
        res.found = f;
        res.exit_row = ROW_W'(er);
        res.exit_col = COL_W'(ec);
        res.path_steps = STEPS_W'(st);
        res.on_path = p;
        return res;
    endfunction

    function automatic dir_row_t row_of(logic [1:0] k, int r, int c, logic w, bit t,
                                        result_t res);
        dir_row_t d;
        d.kind = k;
        d.row = ROW_W'(r);
        d.col = COL_W'(c);
        d.wall = w;
        d.typed = t;
        d.res = res;
        return d;
    endfunction

    // Walk the directed table, then empty it
    task automatic run_table();
        foreach (directed[i])
            send_word(directed[i].kind, directed[i].row, directed[i].col, directed[i].wall,
                      directed[i].typed, directed[i].res);
        directed.delete();
    endtask

    // Random phase: wall writes, solves, path reads and unused-kind words in random order, mostly inside the region
    task automatic random_phase(int items, int wall_pct, int solve_pct);
        int roll;
        int r;
        int c;
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(99);
            if ($urandom_range(9) == 0) begin
                r = $urandom_range(63);
                c = $urandom_range(63);
            end else begin
                r = $urandom_range(border_row);
                c = $urandom_range(border_col);
            end
            if (roll < 50)
                send_word(KIND_WRITE, r, c, $urandom_range(99) < wall_pct, 0, '0);
            else if (roll < 50 + solve_pct)
                send_word(KIND_SOLVE, r, c, 1'($urandom_range(1)), 0, '0);
            else if (roll < 95)
                send_word(KIND_READ, r, c, 1'($urandom_range(1)), 0, '0);
            else
                send_word(KIND_NONE, r, c, 1'($urandom_range(1)), 0, '0);
        end
    endtask

    initial begin
        int lr;
        int lc;
        i_clk = 0;
        solves_sent = 0;
        exits_found = 0;
        reads_sent = 0;
        quiet = 0;
        border_row = 63;
        border_col = 63;
        path_mark = '{default: 0};
        maze_wall = '{default: 0};
        maze_known = '{default: 0};
        i_rst_n <= 0;
        i_cfg_we <= 0;
        i_cfg_idx <= CFG_LAST_ROW;
        i_cfg_data <= '0;
        req.valid <= 0;
        req.kind <= KIND_WRITE;
        req.row <= '0;
        req.col <= '0;
        req.wall <= 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed table at the reset borders; solves touch only written cells
        directed.push_back(row_of(KIND_NONE, 63, 63, 1, 1, '0));
        directed.push_back(row_of(KIND_READ, 0, 0, 0, 1, '0));
        directed.push_back(row_of(KIND_SOLVE, 0, 0, 0, 1, mk_res(1, 0, 0, 0, 0)));
        directed.push_back(row_of(KIND_READ, 0, 0, 0, 1, mk_res(0, 0, 0, 0, 1)));
        directed.push_back(row_of(KIND_SOLVE, 63, 63, 0, 1, mk_res(1, 63, 63, 0, 0)));
        directed.push_back(row_of(KIND_WRITE, 0, 1, 0, 1, '0));
        directed.push_back(row_of(KIND_SOLVE, 1, 1, 0, 1, mk_res(1, 0, 1, 1, 0)));
        directed.push_back(row_of(KIND_READ, 1, 1, 0, 1, mk_res(0, 0, 0, 0, 1)));
        directed.push_back(row_of(KIND_READ, 0, 1, 0, 1, mk_res(0, 0, 0, 0, 1)));
        directed.push_back(row_of(KIND_READ, 63, 63, 0, 1, '0));
        directed.push_back(row_of(KIND_WRITE, 63, 63, 1, 1, '0));
        directed.push_back(row_of(KIND_SOLVE, 63, 63, 0, 1, mk_res(1, 63, 63, 0, 0)));
        directed.push_back(row_of(KIND_WRITE, 63, 63, 0, 1, '0));
        run_table();

        // Directed table inside an opened region
        set_borders(8, 20);
        directed.push_back(row_of(KIND_WRITE, 3, 10, 1, 1, '0));
        directed.push_back(row_of(KIND_SOLVE, 4, 10, 0, 0, '0));
        directed.push_back(row_of(KIND_READ, 1, 11, 0, 0, '0));
        directed.push_back(row_of(KIND_READ, 4, 10, 0, 0, '0));
        directed.push_back(row_of(KIND_SOLVE, 7, 19, 0, 0, '0));
        directed.push_back(row_of(KIND_WRITE, 4, 10, 1, 1, '0));
        directed.push_back(row_of(KIND_SOLVE, 4, 10, 0, 0, '0));
        directed.push_back(row_of(KIND_READ, 3, 10, 0, 0, '0));
        directed.push_back(row_of(KIND_WRITE, 3, 10, 0, 1, '0));
        directed.push_back(row_of(KIND_WRITE, 4, 10, 0, 1, '0));
        run_table();

        // Walled-in start: no exit, marks cleared
        set_borders(4, 4);
        send_word(KIND_WRITE, 1, 2, 1, 0, '0);
        send_word(KIND_WRITE, 2, 3, 1, 0, '0);
        send_word(KIND_WRITE, 3, 2, 1, 0, '0);
        send_word(KIND_WRITE, 2, 1, 1, 0, '0);
        send_word(KIND_SOLVE, 2, 2, 0, 0, '0);
        send_word(KIND_READ, 2, 2, 0, 1, '0);
        // Start beyond the border
        send_word(KIND_SOLVE, 5, 1, 0, 1, '0);
        send_word(KIND_SOLVE, 1, 40, 0, 1, '0);

        // Random phases over a range of maze sizes, extremes included
        random_phase(150, 35, 12);
        set_borders(1, 1);
        random_phase(100, 30, 12);
        set_borders(1, 63);
        random_phase(120, 30, 12);
        set_borders(63, 1);
        random_phase(120, 30, 12);
        set_borders(12, 12);
        quiet = 1;
        random_phase(150, 40, 12);
        quiet = 0;
        set_borders(3, 3);
        random_phase(100, 45, 12);
        set_borders(8, 20);
        random_phase(150, 35, 12);
        lr = $urandom_range(16, 1);
        lc = $urandom_range(16, 1);
        set_borders(lr, lc);
        random_phase(120, 30, 10);
        set_borders(12, 24);
        random_phase(150, 35, 10);

        // Drain and let the block settle
        req.valid <= 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d solves (%0d reached an exit), %0d path reads, %0d results",
                 solves_sent, exits_found, reads_sent, results_seen);
        $display("border settings from 1 to 63 on each side, random walls, output hold-off");
        if (errors == 0) begin
            $display("tb_grid_maze_dfs_solver passed");
        end else begin
            $display("tb_grid_maze_dfs_solver failed");
        end
        $finish;
    end

endmodule

### files.f
design/gmd_pkg.sv
design/gmd_in_if.sv
design/gmd_out_if.sv
design/gmd_ram.sv
design/grid_maze_dfs_solver.sv
verif/tb_grid_maze_dfs_solver.sv
